FILE: hdl/assert_macros.svh
// Assertion macros used by the checker in qpe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define QPE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/qpe_pkg.sv
`default_nettype none
package qpe_pkg;

	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_LF  = 8'h0A;
	localparam logic [7:0] CHR_CR  = 8'h0D;
	localparam logic [7:0] CHR_SP  = 8'h20;
	localparam logic [7:0] CHR_EQ  = 8'h3D;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_A   = 8'h41;

	localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;

	// What one resolved byte turns into on the output side.
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_LIT  = 2'd1,
		ACT_HEX  = 2'd2,
		ACT_CRLF = 2'd3
	} act_kind_t;

	typedef struct packed {
		act_kind_t  kind;
		logic [7:0] chr;
		logic       brk;
	} act_t;

	// One request's worth of output work: the held byte's part, then the new byte's part.
	typedef struct packed {
		act_t held;
		act_t cur;
		logic last;
	} qpe_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/qpe_front.sv
`default_nettype none
module qpe_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      line_limit,
	input  wire logic            accept,
	input  wire logic [7:0]      data_byte,
	input  wire logic            message_last,
	output qpe_pkg::qpe_cmd_t    cmd,
	output logic                 cmd_push
);

	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [7:0] column_q;

	logic [7:0] col_a;
	logic [7:0] col_a_inc;
	logic [7:0] col_b;
	logic [7:0] col_b_inc;
	logic       hold_next;
	logic       b_is_ws;
	logic       next_is_eol;

	function automatic qpe_pkg::act_kind_t enc_kind(input logic [7:0] x, input logic force_hex);
		logic plain;
		logic ws;
		plain = (x >= 8'h21 && x <= 8'h3C) || (x >= 8'h3E && x <= 8'h7E);
		ws = (x == qpe_pkg::CHR_SP) || (x == qpe_pkg::CHR_TAB);
		if (plain || (ws && !force_hex)) begin
			return qpe_pkg::ACT_LIT;
		end
		return qpe_pkg::ACT_HEX;
	endfunction

	assign b_is_ws = (data_byte == qpe_pkg::CHR_SP) || (data_byte == qpe_pkg::CHR_TAB);
	assign next_is_eol = (data_byte == qpe_pkg::CHR_CR) || (data_byte == qpe_pkg::CHR_LF);
	assign col_a_inc = column_q + 8'd1;

	always_comb begin
		cmd = '0;
		cmd.last = message_last;
		cmd.held.chr = held_byte_q;
		cmd.cur.chr = data_byte;
		col_a = column_q;
		hold_next = 1'b0;

		// Resolve the byte held back from the previous request.
		if (held_valid_q) begin
			if (held_byte_q == qpe_pkg::CHR_CR) begin
				if (data_byte != qpe_pkg::CHR_LF) begin
					cmd.held.kind = qpe_pkg::ACT_HEX;
				end
			end else begin
				cmd.held.kind = enc_kind(held_byte_q, next_is_eol);
			end
			if (cmd.held.kind != qpe_pkg::ACT_NONE) begin
				cmd.held.brk = (col_a_inc >= line_limit);
				col_a = cmd.held.brk ? 8'd0 : col_a_inc;
			end
		end

		col_b_inc = col_a + 8'd1;
		col_b = col_a;
		if (data_byte == qpe_pkg::CHR_LF) begin
			cmd.cur.kind = qpe_pkg::ACT_CRLF;
			col_b = 8'd0;
		end else if (!message_last && (b_is_ws || data_byte == qpe_pkg::CHR_CR)) begin
			hold_next = 1'b1;
		end else begin
			cmd.cur.kind = enc_kind(data_byte, 1'b0);
			cmd.cur.brk = (col_b_inc >= line_limit);
			col_b = cmd.cur.brk ? 8'd0 : col_b_inc;
		end
	end

	assign cmd_push = accept &&
		((cmd.held.kind != qpe_pkg::ACT_NONE) || (cmd.cur.kind != qpe_pkg::ACT_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			column_q     <= 8'd0;
		end else if (accept) begin
			if (hold_next) begin
				held_byte_q <= data_byte;
			end
			held_valid_q <= hold_next;
			column_q     <= message_last ? 8'd0 : col_b;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/qpe_queue.sv
`default_nettype none
module qpe_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire qpe_pkg::qpe_cmd_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output qpe_pkg::qpe_cmd_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	qpe_pkg::qpe_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/qpe_back.sv
`default_nettype none
module qpe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire qpe_pkg::qpe_cmd_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             text_char,
	output logic                   run_last,
	output logic                   message_done
);

	// Phases of one request: held byte, its soft break, new byte, its soft break.
	localparam logic [1:0] PH_HELD = 2'd0;
	localparam logic [1:0] PH_HELD_BRK = 2'd1;
	localparam logic [1:0] PH_CUR = 2'd2;
	localparam logic [1:0] PH_CUR_BRK = 2'd3;

	logic [1:0] phase_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       run_last_q;
	logic       done_q;

	logic [1:0] phase_len [4];
	logic [1:0] cur;
	logic       found;
	logic       later;
	logic       end_of_phase;
	logic       is_last;
	logic       load;
	logic [7:0] chr;
	qpe_pkg::act_t act;

	function automatic logic [1:0] len_of(input qpe_pkg::act_kind_t k);
		unique case (k)
			qpe_pkg::ACT_NONE: return 2'd0;
			qpe_pkg::ACT_LIT:  return 2'd1;
			qpe_pkg::ACT_HEX:  return 2'd3;
			qpe_pkg::ACT_CRLF: return 2'd2;
			default:           return 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) begin
			return qpe_pkg::CHR_ZERO + {4'd0, n};
		end
		return qpe_pkg::CHR_A + {4'd0, n} - 8'd10;
	endfunction

	always_comb begin
		phase_len[0] = len_of(head.held.kind);
		phase_len[1] = head.held.brk ? 2'd3 : 2'd0;
		phase_len[2] = len_of(head.cur.kind);
		phase_len[3] = head.cur.brk ? 2'd3 : 2'd0;

		cur = phase_q;
		found = 1'b0;
		for (int p = 0; p < 4; p++) begin
			if (!found && p >= int'(phase_q) && phase_len[p] != 2'd0) begin
				cur = 2'(p);
				found = 1'b1;
			end
		end
		later = 1'b0;
		for (int p = 0; p < 4; p++) begin
			if (p > int'(cur) && phase_len[p] != 2'd0) begin
				later = 1'b1;
			end
		end
	end

	assign end_of_phase = ({1'b0, idx_q} + 3'd1) == {1'b0, phase_len[cur]};
	assign is_last = end_of_phase && !later;

	always_comb begin
		act = (cur == PH_CUR) ? head.cur : head.held;
		chr = act.chr;
		if (cur == PH_HELD_BRK || cur == PH_CUR_BRK) begin
			unique case (idx_q)
				2'd0:    chr = qpe_pkg::CHR_EQ;
				2'd1:    chr = qpe_pkg::CHR_CR;
				default: chr = qpe_pkg::CHR_LF;
			endcase
		end else begin
			unique case (act.kind)
				qpe_pkg::ACT_LIT: chr = act.chr;
				qpe_pkg::ACT_HEX: begin
					unique case (idx_q)
						2'd0:    chr = qpe_pkg::CHR_EQ;
						2'd1:    chr = hex_digit(act.chr[7:4]);
						default: chr = hex_digit(act.chr[3:0]);
					endcase
				end
				qpe_pkg::ACT_CRLF: chr = (idx_q == 2'd0) ? qpe_pkg::CHR_CR : qpe_pkg::CHR_LF;
				default:           chr = act.chr;
			endcase
		end
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HELD;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					phase_q <= PH_HELD;
					idx_q   <= 2'd0;
				end else if (end_of_phase) begin
					phase_q <= cur + 2'd1;
					idx_q   <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q     <= chr;
			run_last_q <= is_last;
			done_q     <= is_last && head.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign text_char    = char_q;
	assign run_last     = run_last_q;
	assign message_done = done_q;

endmodule
`default_nettype wire

FILE: hdl/quoted_printable_encoder.sv
// A request that makes characters passes through the command queue and the output register.
// Throughput: one output character per cycle while commands wait and out_ready allows; a request
// makes 0 to 12 characters, 3 for a hex-encoded byte, and further requests may be taken before they are out.
// Input requests are taken every cycle while the command queue (QUEUE_DEPTH entries) has room.
// Reset (arst_n low, asynchronous): nothing held, column cleared, queue and output emptied,
// line_limit back to 76.
`default_nettype none
module quoted_printable_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       message_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      text_char,
	output logic            run_last,
	output logic            message_done
);

	// The front end resolves held whitespace and column counting at request time and
	// turns each request into at most one command; the back end expands commands into
	// characters one per cycle while out_ready allows. The queue between them lets each side stall alone.

	logic [7:0]        line_limit_q;
	logic              accept;
	logic              cmd_push;
	logic              queue_full;
	logic              head_valid;
	logic              pop;
	qpe_pkg::qpe_cmd_t cmd;
	qpe_pkg::qpe_cmd_t head;

	// The line limit must be written only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= qpe_pkg::LINE_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			line_limit_q <= cfg_wr_data;
		end
	end

	// A request that only holds a byte back is accepted without a queue entry, but
	// readiness does not depend on the payload so that valid may never wait on it.
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	qpe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_limit   (line_limit_q),
		.accept       (accept),
		.data_byte    (data_byte),
		.message_last (message_last),
		.cmd          (cmd),
		.cmd_push     (cmd_push)
	);

	qpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back end owns the output register, so a finished character waiting on
	// out_ready does not block new requests while the queue has room.
	qpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.text_char    (text_char),
		.run_last     (run_last),
		.message_done (message_done)
	);

endmodule
`default_nettype wire

FILE: hdl/qpe_checker.sv
`default_nettype none
`include "assert_macros.svh"
module qpe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] text_char,
	input wire logic       run_last,
	input wire logic       message_done
);

	logic stalled;
	logic done_shown;
	logic char_ok;

	assign stalled    = out_valid && !out_ready;
	assign done_shown = out_valid && message_done;
	assign char_ok    = (text_char >= 8'h20 && text_char <= 8'h7E) || text_char == 8'h09 ||
		text_char == 8'h0D || text_char == 8'h0A;

	`QPE_ASSERT(a_out_hold, stalled |=> out_valid && $stable(text_char), "stalled output changed")
	`QPE_ASSERT(a_done_ends_run, done_shown |-> run_last, "message end off its run end")
	`QPE_ASSERT(a_charset, out_valid |-> char_ok, "encoded text holds a disallowed character")
	`QPE_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "output valid during reset")

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (.*);
`default_nettype wire

FILE: test/qp_text_checker.sv
`timescale 1ns / 100ps
module qp_text_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       message_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] text_char,
	input  logic       run_last,
	input  logic       message_done,
	input  logic       drain_check,
	output int         fail_count,
	output int         pending
);

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [7:0] chr;
		logic       run_end;
		logic       msg_end;
	} text_beat_t;

	text_beat_t expected_text [$];
	logic [7:0] step_chars [$];

	// Shadow copy of the encoder state.
	logic [7:0] line_limit_r;
	logic [7:0] held_r;
	logic       held_v;
	logic [7:0] column_r;

	task automatic report_mismatch(input string msg);
		// Lines stop after a while so a broken block cannot flood the log.
		if (fail_count < MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? qpe_pkg::CHR_ZERO + {4'h0, nib} :
			qpe_pkg::CHR_A + {4'h0, nib} - 8'd10;
	endfunction

	// Emit one resolved byte, then count it toward the soft line break.
	task automatic encode_resolved(input logic [7:0] b, input logic force_hex);
		logic plain;
		logic ws;
		plain = (b >= 8'h21 && b <= 8'h3C) || (b >= 8'h3E && b <= 8'h7E);
		ws = (b == qpe_pkg::CHR_SP) || (b == qpe_pkg::CHR_TAB);
		if (plain || (ws && !force_hex)) begin
			step_chars.push_back(b);
		end else begin
			step_chars.push_back(qpe_pkg::CHR_EQ);
			step_chars.push_back(hex_char(b[7:4]));
			step_chars.push_back(hex_char(b[3:0]));
		end
		column_r = column_r + 8'd1;
		if (column_r >= line_limit_r) begin
			step_chars.push_back(qpe_pkg::CHR_EQ);
			step_chars.push_back(qpe_pkg::CHR_CR);
			step_chars.push_back(qpe_pkg::CHR_LF);
			column_r = 8'd0;
		end
	endtask

	task automatic predict_encoding(input logic [7:0] b, input logic last);
		int n;
		text_beat_t beat;
		step_chars.delete();
		if (held_v) begin
			if (held_r == qpe_pkg::CHR_CR) begin
				// CR LF collapses into the line feed below.
				if (b != qpe_pkg::CHR_LF)
					encode_resolved(held_r, 1'b1);
			end else begin
				encode_resolved(held_r, (b == qpe_pkg::CHR_CR) || (b == qpe_pkg::CHR_LF));
			end
			held_v = 1'b0;
		end
		if (b == qpe_pkg::CHR_LF) begin
			step_chars.push_back(qpe_pkg::CHR_CR);
			step_chars.push_back(qpe_pkg::CHR_LF);
			column_r = 8'd0;
		end else if (!last && (b == qpe_pkg::CHR_SP || b == qpe_pkg::CHR_TAB ||
				b == qpe_pkg::CHR_CR)) begin
			held_r = b;
			held_v = 1'b1;
		end else begin
			encode_resolved(b, 1'b0);
		end
		if (last) begin
			held_v = 1'b0;
			column_r = 8'd0;
		end
		n = step_chars.size();
		for (int k = 0; k < n; k++) begin
			beat.chr = step_chars[k];
			beat.run_end = (k == n - 1);
			beat.msg_end = (k == n - 1) && last;
			expected_text.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			line_limit_r = qpe_pkg::LINE_LIMIT_RESET;
			held_r = 8'd0;
			held_v = 1'b0;
			column_r = 8'd0;
			expected_text.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				line_limit_r = cfg_wr_data;
			if (in_valid && in_ready)
				predict_encoding(data_byte, message_last);
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("character %h with nothing expected", text_char));
				end else begin
					want = expected_text.pop_front();
					if (text_char !== want.chr)
						report_mismatch($sformatf("text_char %h, want %h", text_char, want.chr));
					if (run_last !== want.run_end)
						report_mismatch($sformatf("run_last %b, want %b on %h",
							run_last, want.run_end, want.chr));
					if (message_done !== want.msg_end)
						report_mismatch($sformatf("message_done %b, want %b on %h",
							message_done, want.msg_end, want.chr));
				end
			end
			if (drain_check && expected_text.size() != 0)
				report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
			pending <= expected_text.size();
		end
	end

endmodule

FILE: test/tb_quoted_printable_encoder.sv
`timescale 1ns / 100ps
module tb_quoted_printable_encoder;

	// Length of the long receiver hold-off that makes the block back up.
	localparam int HOLD_CYCLES = 300;
	// Quiet cycles allowed after the last result before a register write or the verdict.
	// Characters pass through the command queue and the output register, so this is ample.
	localparam int SETTLE_CYCLES = 8;
	// Cycles with no request moving on either channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_MOSTLY,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       message_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] text_char;
	logic       run_last;
	logic       message_done;

	logic       drain_check;
	int         fail_count;
	int         pending;

	// Sender and receiver controls. The stimulus bumps hold_requests to ask the
	// receiver for one long hold-off; the receiver tracks how many it has served.
	int         hold_requests;
	logic       gaps_on;
	int         burst_left;
	int         items_sent;
	int         quiet_cycles;

	// Directed requests: bit 8 is message_last, bits 7:0 the byte.
	logic [8:0] directed_seq [$];

	quoted_printable_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.message_last(message_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_char   (text_char),
		.run_last    (run_last),
		.message_done(message_done)
	);

	qp_text_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.message_last(message_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.text_char   (text_char),
		.run_last    (run_last),
		.message_done(message_done),
		.drain_check (drain_check),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog restarts whenever a request moves on either channel. Reset
	// also holds it at zero.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver. It drifts between several ready patterns of random length so that
	// stalls land on every character of a run, including runs of always-ready. When
	// the stimulus asks for a hold-off it drops ready for a long counted stretch.
	initial begin : rx_pattern
		rx_mode_t mode;
		int mode_left;
		int beat;
		int holds_done;
		mode = RX_FLOW;
		mode_left = 0;
		beat = 0;
		holds_done = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				beat++;
				unique case (mode)
					RX_FLOW: out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= beat[2];
				endcase
			end
		end
	end

	// Present one request and hold it until the block takes it. Requests go out in
	// bursts; between bursts the sender may drop valid for a few cycles when gaps
	// are enabled. Valid is only ever changed once per falling edge.
	task automatic offer(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		message_last <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Byte mix weighted toward the interesting classes: plain text, whitespace that
	// has to be held, CR and LF, the equals sign and bytes that must be hex-encoded.
	function automatic logic [7:0] pick_byte(input logic allow_lf);
		int r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 40)
			b = 8'($urandom_range(8'h21, 8'h7E));
		else if (r < 55)
			b = $urandom_range(0, 1) ? qpe_pkg::CHR_SP : qpe_pkg::CHR_TAB;
		else if (r < 63)
			b = qpe_pkg::CHR_CR;
		else if (r < 72)
			b = qpe_pkg::CHR_LF;
		else if (r < 82)
			b = 8'($urandom());
		else if (r < 87)
			b = qpe_pkg::CHR_EQ;
		else if (r < 95)
			b = 8'($urandom_range(8'h80, 8'hFF));
		else
			b = $urandom_range(0, 1) ? 8'h00 : 8'h7F;
		if (!allow_lf && b == qpe_pkg::CHR_LF)
			b = qpe_pkg::CHR_EQ;
		return b;
	endfunction

	// One message of len bytes, the last one flagged. A CR is often followed by a
	// proper LF so that hard line breaks are well-formed most of the time.
	task automatic send_message(input int len, input logic allow_lf);
		int i;
		logic [7:0] b;
		i = 0;
		while (i < len) begin
			b = pick_byte(allow_lf);
			if (b == qpe_pkg::CHR_CR && allow_lf && i + 1 < len &&
					$urandom_range(0, 1) == 1) begin
				offer(qpe_pkg::CHR_CR, 1'b0);
				offer(qpe_pkg::CHR_LF, i + 2 == len);
				i += 2;
			end else begin
				offer(b, i + 1 == len);
				i++;
			end
		end
	endtask

	task automatic run_phase(input int quota, input int max_len);
		int stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at)
			send_message($urandom_range(1, max_len), 1'b1);
	endtask

	// Drop valid, wait until every predicted character has come out, and then let
	// the block sit quiet a few cycles so it is idle for a register write.
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_limit(input logic [7:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		message_last = 1'b0;
		drain_check = 1'b0;
		hold_requests = 0;
		gaps_on = 1'b0;
		burst_left = 0;
		items_sent = 0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset line limit. First the byte class edges: NUL,
		// 0xFF, both ends of each literal range, the equals sign, DEL and a high byte.
		// Then the held-byte cases: space before a letter, tab before CR, CR before
		// LF, space before space, space before LF, CR before a letter, CR before CR,
		// and message ends on a tab, a lone CR, a lone space and a lone LF.
		directed_seq = '{
			{1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h21}, {1'b0, 8'h3C},
			{1'b0, qpe_pkg::CHR_EQ},
			{1'b0, 8'h3E}, {1'b0, 8'h7E}, {1'b0, 8'h7F}, {1'b1, 8'h80},
			{1'b0, qpe_pkg::CHR_SP}, {1'b0, 8'h61}, {1'b0, qpe_pkg::CHR_TAB},
			{1'b0, qpe_pkg::CHR_CR}, {1'b0, qpe_pkg::CHR_LF},
			{1'b0, qpe_pkg::CHR_SP}, {1'b0, qpe_pkg::CHR_SP}, {1'b0, qpe_pkg::CHR_LF},
			{1'b0, qpe_pkg::CHR_CR}, {1'b0, 8'h78},
			{1'b0, qpe_pkg::CHR_CR}, {1'b0, qpe_pkg::CHR_CR}, {1'b1, qpe_pkg::CHR_TAB},
			{1'b1, qpe_pkg::CHR_CR}, {1'b1, qpe_pkg::CHR_SP}, {1'b1, qpe_pkg::CHR_LF}
		};
		foreach (directed_seq[i])
			offer(directed_seq[i][7:0], directed_seq[i][8]);
		settle_idle();

		// Limit of 1: every counted byte is followed by a soft break.
		set_limit(8'd1);
		gaps_on = 1'b1;
		run_phase(27, 8);
		settle_idle();

		// Largest limit, reached by one long message without line feeds.
		set_limit(8'd255);
		gaps_on = 1'b0;
		send_message(256, 1'b0);
		settle_idle();

		// Receiver holds off for a long stretch while the sender keeps pushing, so
		// the block fills up and has to stall its input.
		set_limit(8'd2);
		hold_requests++;
		run_phase(30, 6);
		settle_idle();

		set_limit(8'($urandom_range(3, 12)));
		gaps_on = 1'b1;
		run_phase(50, 16);
		settle_idle();

		set_limit(8'($urandom_range(1, 255)));
		gaps_on = 1'($urandom_range(0, 1));
		run_phase(20, 20);
		settle_idle();

		set_limit(qpe_pkg::LINE_LIMIT_RESET);
		gaps_on = 1'b1;
		run_phase(30, 24);
		settle_idle();

		// Anything still expected at this point never came out.
		drain_check = 1'b1;
		@(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/qpe_pkg.sv
hdl/qpe_front.sv
hdl/qpe_queue.sv
hdl/qpe_back.sv
hdl/quoted_printable_encoder.sv
hdl/qpe_checker.sv
test/qp_text_checker.sv
test/tb_quoted_printable_encoder.sv
